// File: hw/rtl/adgt_pkg.sv
// shared types and constants for the arcade drive mixer with gyro trim
// used by adgt_rescale and arcade_drive_mixer_gyro_trim_core, no dependencies
`default_nettype none

package adgt_pkg;

    localparam int DRIVE_W         = 8;
    localparam int DRIVE_LIMIT     = 127;
    localparam int ARM_MARGIN      = 50;
    localparam int TURN_HALF_BELOW = 80;
    localparam int TURN_3Q_BELOW   = 100;
    localparam int QUO_BITS        = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX,
        ST_RUN,
        ST_TRIM,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        REG_GYRO_BASELINE,
        REG_ARM_LOW_LIMIT,
        REG_STICK_DEADBAND,
        REG_TRIM_GAIN
    } cfg_reg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rs_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/adgt_rescale.sv
// shared restoring divider that rescales left and right by 127 / peak in turn
// depends on adgt_pkg
`default_nettype none

module adgt_rescale (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic signed [9:0]   left_in,
    input  wire logic signed [9:0]   right_in,
    input  wire logic        [8:0]   peak,
    output adgt_pkg::rs_sts_t        sts,
    output logic signed [7:0]        left_out,
    output logic signed [7:0]        right_out
);
    import adgt_pkg::*;

    localparam int CntW = $clog2(QUO_BITS);

    logic                  side_reg, side_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  neg_reg, neg_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic [8:0]            rem_reg, rem_next;
    logic [QUO_BITS-1:0]   quo_reg, quo_next;
    logic signed [7:0]     left_out_reg, left_out_next;
    logic signed [7:0]     right_out_reg, right_out_next;

    logic                  last_step;
    logic                  load_right;
    logic signed [9:0]     load_val;
    logic [9:0]            load_abs;
    logic [15:0]           load_prod;
    logic [9:0]            trial;
    logic                  ge;
    logic [9:0]            trial_sub;
    logic [QUO_BITS-1:0]   quo_step;
    logic [7:0]            q_signed;

    always_comb
    begin
        last_step  = (cnt_reg == CntW'(QUO_BITS - 1));
        load_right = busy_reg && last_step && !side_reg;
        load_val   = load_right ? right_in : left_in;
        load_abs   = load_val[9] ? (10'd0 - load_val) : load_val;
        // times 127 as shift and subtract
        load_prod  = {load_abs[8:0], 7'd0} - {7'd0, load_abs[8:0]};
        trial      = {rem_reg, quo_reg[QUO_BITS-1]};
        ge         = (trial >= {1'b0, peak});
        trial_sub  = trial - {1'b0, peak};
        quo_step   = {quo_reg[QUO_BITS-2:0], ge};
        q_signed   = neg_reg ? (8'd0 - {1'b0, quo_step}) : {1'b0, quo_step};
    end

    always_comb
    begin
        side_next      = side_reg;
        busy_next      = busy_reg;
        done_next      = 1'b0;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        if (start)
        begin
            side_next = 1'b0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? trial_sub[8:0] : trial[8:0];
            quo_next = quo_step;
            cnt_next = cnt_reg + CntW'(1);
            if (last_step)
            begin
                if (!side_reg)
                begin
                    left_out_next = q_signed;
                    side_next     = 1'b1;
                end
                else
                begin
                    right_out_next = q_signed;
                    busy_next      = 1'b0;
                    done_next      = 1'b1;
                end
            end
        end
        // quotient is below 2^7, so the top dividend bits already sit below peak
        if (start || load_right)
        begin
            neg_next = load_val[9];
            cnt_next = '0;
            rem_next = {1'b0, load_prod[14:7]};
            quo_next = load_prod[QUO_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            side_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            side_reg <= side_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg       <= neg_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/arcade_drive_mixer_gyro_trim_core.sv
// arcade drive mixer with gyro trim: deadband, turn scaling, mix, rescale, trim
// depends on adgt_pkg and adgt_rescale
//
// channel  dir  handshake               payload
// s_axis   in   tvalid/tready           tdata: forward, turn, gyro sample, arm
// m_axis   out  tvalid/tready           tdata: left_drive, right_drive
// cfg      in   cfg_we                  cfg_index, cfg_data
//
// a request steps through the mix, run, trim and finish states; in the run state
// the history sum adds one stored error per cycle, and when the mix exceeds 127
// both sides pass in turn through the shared 7-step divider
// reset restores the register defaults and clears the error history
// a result held on m_axis stalls only the last step of the next request
`default_nettype none

module arcade_drive_mixer_gyro_trim_core #(
    parameter int HISTORY_DEPTH = 4,
    parameter int SENSOR_BITS   = 12,
    localparam int InW = ((16 + 2 * SENSOR_BITS + 7) / 8) * 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // forward_stick, turn_stick, gyro_sample, arm_position, zero pad
    input  wire logic [InW-1:0]    s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // left_drive, right_drive
    output logic [15:0]            m_axis_tdata,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [SENSOR_BITS-1:0] cfg_data
);
    import adgt_pkg::*;

    localparam int SB   = SENSOR_BITS;
    localparam int AccW = SB + 1 + $clog2(HISTORY_DEPTH + 1);
    localparam int HCW  = $clog2(HISTORY_DEPTH + 1);
    localparam int HIW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    // configuration
    logic [SB-1:0]          gyro_baseline_reg;
    logic [SB-1:0]          arm_low_limit_reg;
    logic [6:0]             stick_deadband_reg;
    logic [7:0]             trim_gain_reg;

    state_t                 state_reg, state_next;

    logic [7:0]             fwd_raw_reg, fwd_raw_next;
    logic [7:0]             turn_raw_reg, turn_raw_next;
    logic [SB-1:0]          sample_reg, sample_next;
    logic [SB-1:0]          arm_reg, arm_next;

    logic signed [9:0]      left_mix_reg, left_mix_next;
    logic signed [9:0]      right_mix_reg, right_mix_next;
    logic [8:0]             peak_reg, peak_next;
    logic                   need_div_reg, need_div_next;
    logic                   rs_go_reg, rs_go_next;
    logic                   div_done_reg, div_done_next;
    logic signed [SB:0]     err_reg, err_next;
    logic signed [AccW-1:0] acc_reg, acc_next;
    logic [HCW-1:0]         hidx_reg, hidx_next;
    logic                   trim_gate_reg, trim_gate_next;
    logic [7:0]             trim_mag_reg, trim_mag_next;
    logic signed [SB:0]     hist_reg [HISTORY_DEPTH];

    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             left_out_reg, left_out_next;
    logic [7:0]             right_out_reg, right_out_next;

    logic                   in_accept;
    logic                   out_free;
    logic                   run_done;
    logic                   rs_start;
    rs_sts_t                rs_sts;
    logic signed [7:0]      rs_left;
    logic signed [7:0]      rs_right;

    // mix datapath
    logic [7:0]             fwd_mag, turn_mag, turn_dz, turn_sm;
    logic [8:0]             turn_x3;
    logic signed [8:0]      fwd_val, turn_val;
    logic signed [9:0]      left_sum, right_sum;
    logic [9:0]             left_abs, right_abs;
    logic [8:0]             peak_val;
    logic [SB:0]            arm_plus;

    // trim datapath
    logic [AccW-1:0]        acc_mag;
    logic [AccW+7:0]        trim_prod;
    logic [AccW-1:0]        trim_full;

    // output datapath
    logic signed [7:0]      base_left, base_right;
    logic signed [9:0]      fin_left, fin_right;

    adgt_rescale u_rescale (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rs_start),
        .left_in   (left_mix_reg),
        .right_in  (right_mix_reg),
        .peak      (peak_reg),
        .sts       (rs_sts),
        .left_out  (rs_left),
        .right_out (rs_right)
    );

    always_comb
    begin
        out_free = !out_valid_reg || m_axis_tready;
        run_done = (hidx_reg == HCW'(HISTORY_DEPTH))
                   && (!need_div_reg || div_done_reg || rs_sts.done);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = ST_MIX;
            end
            ST_MIX:    state_next = ST_RUN;
            ST_RUN:
            begin
                if (run_done)
                    state_next = ST_TRIM;
            end
            ST_TRIM:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        rs_start      = (state_reg == ST_RUN) && rs_go_reg;
        in_accept     = s_axis_tvalid && s_axis_tready;
    end

    // mix arithmetic
    always_comb
    begin
        fwd_mag  = fwd_raw_reg[7] ? (8'd0 - fwd_raw_reg) : fwd_raw_reg;
        turn_mag = turn_raw_reg[7] ? (8'd0 - turn_raw_reg) : turn_raw_reg;
        fwd_val  = (fwd_mag <= {1'b0, stick_deadband_reg}) ? 9'sd0
                   : {fwd_raw_reg[7], fwd_raw_reg};
        turn_dz  = (turn_mag <= {1'b0, stick_deadband_reg}) ? 8'd0 : turn_mag;
        turn_x3  = {1'b0, turn_dz} + {turn_dz, 1'b0};
        if (turn_dz < 8'(TURN_HALF_BELOW))
            turn_sm = {1'b0, turn_dz[7:1]};
        else if (turn_dz < 8'(TURN_3Q_BELOW))
            turn_sm = {1'b0, turn_x3[8:2]};
        else
            turn_sm = turn_dz;
        turn_val  = turn_raw_reg[7] ? (9'sd0 - $signed({1'b0, turn_sm}))
                    : $signed({1'b0, turn_sm});
        left_sum  = 10'(fwd_val) + 10'(turn_val);
        right_sum = 10'(fwd_val) - 10'(turn_val);
        left_abs  = left_sum[9] ? (10'd0 - left_sum) : left_sum;
        right_abs = right_sum[9] ? (10'd0 - right_sum) : right_sum;
        peak_val  = (right_abs > left_abs) ? right_abs[8:0] : left_abs[8:0];
        arm_plus  = {1'b0, arm_reg} + (SB + 1)'(ARM_MARGIN);
    end

    // trim and output arithmetic
    always_comb
    begin
        acc_mag    = AccW'(0) - acc_reg;
        trim_prod  = {8'd0, acc_mag} * {{AccW{1'b0}}, trim_gain_reg};
        trim_full  = trim_prod[AccW+7:8];
        base_left  = need_div_reg ? rs_left : left_mix_reg[7:0];
        base_right = need_div_reg ? rs_right : right_mix_reg[7:0];
        fin_left   = 10'(base_left) - $signed({2'b00, trim_mag_reg});
        fin_right  = 10'(base_right) - $signed({2'b00, trim_mag_reg});
    end

    // datapath next values
    always_comb
    begin
        fwd_raw_next   = fwd_raw_reg;
        turn_raw_next  = turn_raw_reg;
        sample_next    = sample_reg;
        arm_next       = arm_reg;
        left_mix_next  = left_mix_reg;
        right_mix_next = right_mix_reg;
        peak_next      = peak_reg;
        need_div_next  = need_div_reg;
        rs_go_next     = rs_go_reg;
        div_done_next  = div_done_reg;
        err_next       = err_reg;
        acc_next       = acc_reg;
        hidx_next      = hidx_reg;
        trim_gate_next = trim_gate_reg;
        trim_mag_next  = trim_mag_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    fwd_raw_next  = s_axis_tdata[7:0];
                    turn_raw_next = s_axis_tdata[15:8];
                    sample_next   = s_axis_tdata[16+SB-1:16];
                    arm_next      = s_axis_tdata[16+2*SB-1:16+SB];
                end
            end
            ST_MIX:
            begin
                left_mix_next  = left_sum;
                right_mix_next = right_sum;
                peak_next      = peak_val;
                need_div_next  = (peak_val > 9'(DRIVE_LIMIT));
                rs_go_next     = (peak_val > 9'(DRIVE_LIMIT));
                div_done_next  = 1'b0;
                err_next       = $signed({1'b0, gyro_baseline_reg})
                                 - $signed({1'b0, sample_reg});
                acc_next       = AccW'($signed({1'b0, gyro_baseline_reg})
                                 - $signed({1'b0, sample_reg}));
                hidx_next      = '0;
                trim_gate_next = (arm_plus < {1'b0, arm_low_limit_reg});
            end
            ST_RUN:
            begin
                rs_go_next = 1'b0;
                if (rs_sts.done)
                    div_done_next = 1'b1;
                if (hidx_reg != HCW'(HISTORY_DEPTH))
                begin
                    acc_next  = acc_reg + AccW'(hist_reg[hidx_reg[HIW-1:0]]);
                    hidx_next = hidx_reg + HCW'(1);
                end
            end
            ST_TRIM:
            begin
                if (trim_gate_reg && acc_reg[AccW-1])
                    trim_mag_next = (trim_full > AccW'(255)) ? 8'd255 : trim_full[7:0];
                else
                    trim_mag_next = 8'd0;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    left_out_next  = (fin_left < -10'sd127) ? 8'(-DRIVE_LIMIT)
                                     : fin_left[7:0];
                    right_out_next = (fin_right < -10'sd127) ? 8'(-DRIVE_LIMIT)
                                     : fin_right[7:0];
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_axis_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_baseline_reg  <= SB'(1) << (SB - 1);
            arm_low_limit_reg  <= '0;
            stick_deadband_reg <= 7'd10;
            trim_gain_reg      <= 8'd51;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GYRO_BASELINE:  gyro_baseline_reg  <= cfg_data;
                REG_ARM_LOW_LIMIT:  arm_low_limit_reg  <= cfg_data;
                REG_STICK_DEADBAND: stick_deadband_reg <= cfg_data[6:0];
                REG_TRIM_GAIN:      trim_gain_reg      <= cfg_data[7:0];
                default:            trim_gain_reg      <= trim_gain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            need_div_reg  <= 1'b0;
            rs_go_reg     <= 1'b0;
            div_done_reg  <= 1'b0;
            hidx_reg      <= '0;
            trim_gate_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            need_div_reg  <= need_div_next;
            rs_go_reg     <= rs_go_next;
            div_done_reg  <= div_done_next;
            hidx_reg      <= hidx_next;
            trim_gate_reg <= trim_gate_next;
        end
    end

    // error delay line, newest at entry 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
                hist_reg[i] <= '0;
        end
        else if (state_reg == ST_TRIM)
        begin
            hist_reg[0] <= err_reg;
            for (int i = 1; i < HISTORY_DEPTH; i++)
                hist_reg[i] <= hist_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_raw_reg   <= fwd_raw_next;
        turn_raw_reg  <= turn_raw_next;
        sample_reg    <= sample_next;
        arm_reg       <= arm_next;
        left_mix_reg  <= left_mix_next;
        right_mix_reg <= right_mix_next;
        peak_reg      <= peak_next;
        err_reg       <= err_next;
        acc_reg       <= acc_next;
        trim_mag_reg  <= trim_mag_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {right_out_reg, left_out_reg};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while previous one in progress");

    a_divider_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        rs_sts.busy |-> state_reg == ST_RUN)
        else $error("divider busy outside run phase");

    a_divider_only_when_needed: assert property (@(posedge clk) disable iff (!rst_n)
        rs_start |-> need_div_reg)
        else $error("divider started without overflow");

    a_history_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hidx_reg <= HCW'(HISTORY_DEPTH))
        else $error("history index past depth");

    a_output_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> left_out_reg != 8'h80 && right_out_reg != 8'h80)
        else $error("drive output outside +-127");
`endif

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for arcade_drive_mixer_gyro_trim_core: drives stick, gyro and arm
// requests, predicts left/right drive with its own mixer and gyro trim model
// depends on adgt_pkg and the core rtl only
module testbench;
    import adgt_pkg::*;

    localparam int HIST_DEPTH    = 4;
    localparam int SENS_W        = 12;
    localparam int IN_W          = 40;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic signed [7:0] right;
        logic signed [7:0] left;
    } drive_pair_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [15:0]       m_axis_tdata;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [SENS_W-1:0] cfg_data;

    // register copies and error history of the predictor
    logic [11:0] baseline_q;
    logic [11:0] arm_limit_q;
    logic [6:0]  deadband_q;
    logic [7:0]  gain_q;
    int          err_hist [HIST_DEPTH];

    drive_pair_t pending_drives [$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          error_count;
    int          requests_sent;
    int          drives_checked;
    int          settings_applied;

    arcade_drive_mixer_gyro_trim_core #(
        .HISTORY_DEPTH (HIST_DEPTH),
        .SENSOR_BITS   (SENS_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic drive_pair_t mix_drive(input logic signed [7:0] fwd_in,
                                              input logic signed [7:0] turn_in,
                                              input logic [11:0] gyro,
                                              input logic [11:0] arm);
        drive_pair_t res;
        int fwd, turn, left, right, peak, err, sum, trim;
        fwd  = int'(fwd_in);
        turn = int'(turn_in);
        if (magnitude(fwd) <= int'(deadband_q))
            fwd = 0;
        if (magnitude(turn) <= int'(deadband_q))
            turn = 0;
        if (magnitude(turn) < TURN_HALF_BELOW)
            turn = turn / 2;
        else if (magnitude(turn) < TURN_3Q_BELOW)
            turn = (turn * 3) / 4;
        left  = fwd + turn;
        right = fwd - turn;
        peak  = (magnitude(right) > magnitude(left)) ? magnitude(right) : magnitude(left);
        if (peak > DRIVE_LIMIT)
        begin
            left  = (DRIVE_LIMIT * left) / peak;
            right = (DRIVE_LIMIT * right) / peak;
        end
        err = int'(baseline_q) - int'(gyro);
        sum = err;
        foreach (err_hist[i])
            sum += err_hist[i];
        for (int i = HIST_DEPTH - 1; i > 0; i--)
            err_hist[i] = err_hist[i-1];
        err_hist[0] = err;
        if (int'(arm) < int'(arm_limit_q) - ARM_MARGIN && sum < 0)
        begin
            trim  = (sum * int'(gain_q)) / 256;
            left  += trim;
            right += trim;
        end
        left  = (left > DRIVE_LIMIT) ? DRIVE_LIMIT : ((left < -DRIVE_LIMIT) ? -DRIVE_LIMIT : left);
        right = (right > DRIVE_LIMIT) ? DRIVE_LIMIT :
                ((right < -DRIVE_LIMIT) ? -DRIVE_LIMIT : right);
        res.left  = 8'(left);
        res.right = 8'(right);
        return res;
    endfunction

    // one request, held until accepted; valid stays high for a following request
    task automatic send_request(input logic signed [7:0] fwd, input logic signed [7:0] turn,
                                input logic [11:0] gyro, input logic [11:0] arm);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  = {arm, gyro, turn, fwd};
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_drives.push_back(mix_drive(fwd, turn, gyro, arm));
        requests_sent++;
    endtask

    task automatic wait_for_drives();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [SENS_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        case (idx)
            REG_GYRO_BASELINE:  baseline_q  = val;
            REG_ARM_LOW_LIMIT:  arm_limit_q = val;
            REG_STICK_DEADBAND: deadband_q  = val[6:0];
            REG_TRIM_GAIN:      gain_q      = val[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic signed [7:0] pick_stick();
        int m;
        case ($urandom_range(3))
            0: return 8'($urandom);
            1:
            begin
                m = int'(deadband_q) + $urandom_range(2) - 1;
                m = (m < 0) ? 0 : m;
            end
            2: m = $urandom_range(101, 78);
            default: m = $urandom_range(127, 100);
        endcase
        return $urandom_range(1) ? 8'(-m) : 8'(m);
    endfunction

    function automatic logic [11:0] pick_setting(input logic [11:0] a, input logic [11:0] b,
                                                 input logic [11:0] c);
        case ($urandom_range(3))
            0: return a;
            1: return b;
            2: return c;
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic send_random_request();
        logic [11:0] gyro, arm;
        int g;
        case ($urandom_range(2))
            0: g = $urandom_range(4095);
            1: g = int'(baseline_q) + $urandom_range(400);
            default: g = int'(baseline_q) - $urandom_range(400);
        endcase
        gyro = (g > 4095) ? 12'd4095 : ((g < 0) ? 12'd0 : 12'(g));
        if (arm_limit_q >= 51 && $urandom_range(2) != 0)
            arm = 12'($urandom_range(int'(arm_limit_q) - 51, 0));
        else
            arm = 12'($urandom_range(4095));
        send_request(pick_stick(), pick_stick(), gyro, arm);
    endtask

    // result check
    always @(posedge clk)
    begin : drive_check
        drive_pair_t want;
        drive_pair_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_drives.size() == 0)
            begin
                $display("%0t: drive result with no request pending, expected none, actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = pending_drives.pop_front();
                drives_checked++;
                if (got.left !== want.left)
                begin
                    $display("%0t: left_drive expected %0d actual %0d",
                             $time, want.left, got.left);
                    error_count++;
                end
                if (got.right !== want.right)
                begin
                    $display("%0t: right_drive expected %0d actual %0d",
                             $time, want.right, got.right);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // reset defaults: deadband edges, turn scaling bands, rescale, -128 sticks
    task automatic test_defaults();
        send_request(8'sd0, 8'sd0, 12'd2048, 12'd0);
        send_request(8'sd10, -8'sd10, 12'd0, 12'd4095);
        send_request(8'sd11, -8'sd11, 12'd4095, 12'd0);
        send_request(8'sd127, 8'sd0, 12'd1, 12'hAAA);
        send_request(-8'sd127, 8'sd0, 12'd4094, 12'h555);
        send_request(-8'sd128, 8'sd0, 12'd2048, 12'd0);
        send_request(8'sd0, -8'sd128, 12'd2048, 12'd0);
        send_request(8'sd0, 8'sd79, 12'd2000, 12'd0);
        send_request(8'sd0, 8'sd80, 12'd2100, 12'd0);
        send_request(8'sd0, -8'sd99, 12'd2048, 12'd0);
        send_request(8'sd0, 8'sd100, 12'd2048, 12'd0);
        send_request(8'sd127, 8'sd127, 12'd2048, 12'd0);
        send_request(-8'sd127, 8'sd90, 12'd2048, 12'd0);
        send_request(8'sd100, -8'sd45, 12'd2048, 12'd0);
        wait_for_drives();
    endtask

    // trim path: arm limit boundary, saturation, positive sum, low arm limit
    task automatic test_gyro_trim();
        write_reg(REG_GYRO_BASELINE, 12'd0);
        write_reg(REG_ARM_LOW_LIMIT, 12'd4095);
        write_reg(REG_STICK_DEADBAND, 12'd0);
        write_reg(REG_TRIM_GAIN, 12'd255);
        settings_applied++;
        send_request(8'sd5, -8'sd3, 12'd4095, 12'd0);
        send_request(8'sd0, 8'sd0, 12'd4095, 12'd4044);
        send_request(8'sd0, 8'sd0, 12'd4095, 12'd4045);
        send_request(8'sd127, 8'sd127, 12'd4095, 12'd0);
        send_request(-8'sd128, -8'sd128, 12'd4095, 12'd0);
        wait_for_drives();
        write_reg(REG_GYRO_BASELINE, 12'd4095);
        write_reg(REG_TRIM_GAIN, 12'd0);
        settings_applied++;
        send_request(8'sd50, 8'sd20, 12'd100, 12'd0);
        send_request(8'sd1, 8'sd1, 12'd4095, 12'd0);
        wait_for_drives();
        write_reg(REG_GYRO_BASELINE, 12'd0);
        write_reg(REG_ARM_LOW_LIMIT, 12'd50);
        write_reg(REG_TRIM_GAIN, 12'd255);
        settings_applied++;
        send_request(8'sd30, -8'sd30, 12'd4095, 12'd0);
        wait_for_drives();
        write_reg(REG_ARM_LOW_LIMIT, 12'd51);
        settings_applied++;
        send_request(8'sd30, -8'sd30, 12'd4095, 12'd0);
        send_request(8'sd30, -8'sd30, 12'd4095, 12'd1);
        wait_for_drives();
    endtask

    task automatic test_random_traffic(input int per_setting, input int settings,
                                       input int s_idle, input int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int s = 0; s < settings; s++)
        begin
            wait_for_drives();
            write_reg(REG_GYRO_BASELINE, pick_setting(12'd0, 12'd4095, 12'd2048));
            write_reg(REG_ARM_LOW_LIMIT, pick_setting(12'd0, 12'd51, 12'd4095));
            write_reg(REG_STICK_DEADBAND, pick_setting(12'd0, 12'd127, 12'($urandom_range(20))));
            write_reg(REG_TRIM_GAIN, pick_setting(12'd0, 12'd255, 12'd51));
            settings_applied++;
            for (int i = 0; i < per_setting; i++)
            begin
                // sender holds off until the pipeline is empty
                if (s == 0 && i == per_setting / 2)
                    wait_for_drives();
                send_random_request();
            end
        end
        wait_for_drives();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        cfg_we           = 1'b0;
        cfg_index        = REG_GYRO_BASELINE;
        cfg_data         = '0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        error_count      = 0;
        requests_sent    = 0;
        drives_checked   = 0;
        settings_applied = 1;
        baseline_q       = 12'd2048;
        arm_limit_q      = 12'd0;
        deadband_q       = 7'd10;
        gain_q           = 8'd51;
        foreach (err_hist[i])
            err_hist[i] = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_defaults();
        test_gyro_trim();
        test_random_traffic(58, 4, 18, 58);
        test_random_traffic(58, 4, 58, 18);
        test_random_traffic(58, 4, 0, 0);

        if (pending_drives.size() != 0)
        begin
            $display("%0t: %0d drive results never arrived", $time, pending_drives.size());
            error_count++;
        end
        $display("covered %0d stick/gyro requests, %0d drive pairs checked, %0d register settings",
                 requests_sent, drives_checked, settings_applied);
        $display("with deadband, turn scaling, rescale and gyro trim under mixed stalls");
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
